// File: rtl/osdtb_pkg.sv
package osdtb_pkg;

	// Defaults for the top-level parameters.
	localparam int LINE_CHARS_DEF = 32;
	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths.
	localparam int GEOM_BITS     = 12;
	localparam int COL_BITS      = 5;
	localparam int CODE_BITS     = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int MAX_COLS      = 2 ** COL_BITS;

	// Default depth of the character store: two lines of MAX_COLS cells.
	localparam int CELL_ADDR_BITS_DEF = COL_BITS + 1;

	// Font geometry.
	localparam int GLYPH_W     = 5;
	localparam int GLYPH_H     = 7;
	localparam int GSCALE      = 2;
	localparam int GLYPH_PX_W  = GLYPH_W * GSCALE;
	localparam int GLYPH_PX_H  = GLYPH_H * GSCALE;
	localparam int PITCH       = GLYPH_PX_W + 2;
	localparam int FONT_GLYPHS = 59;

	// Placement of the text and border inside the badge.
	localparam int TEXT_X_OFF   = 10;
	localparam int TEXT_Y_OFF   = 8;
	localparam int LINE_PITCH_Y = 16;
	localparam int BORDER_ROWS  = 2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// Character codes.
	localparam logic [7:0] CHAR_FIRST = 8'd32;
	localparam logic [7:0] CHAR_LAST  = 8'd90;
	localparam logic [7:0] LOWER_A    = 8'd97;
	localparam logic [7:0] LOWER_Z    = 8'd122;
	localparam logic [7:0] CASE_FOLD  = 8'd32;

	// Register reset values.
	localparam logic [GEOM_BITS-1:0] ORIGIN_X_RST     = 12'd20;
	localparam logic [GEOM_BITS-1:0] ORIGIN_Y_RST     = 12'd20;
	localparam logic [GEOM_BITS-1:0] BADGE_WIDTH_RST  = 12'd260;
	localparam logic [GEOM_BITS-1:0] BADGE_HEIGHT_RST = 12'd44;
	localparam logic [31:0]          BG_COLOR_RST     = 32'hEE18_1818;
	localparam logic [23:0]          BORDER_COLOR_RST = 24'h00_D4AA;
	localparam logic [23:0]          LINE0_COLOR_RST  = 24'h00_FFFF;
	localparam logic [23:0]          LINE1_COLOR_RST  = 24'hFF_FFFF;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ORIGIN_X,
		CFG_ORIGIN_Y,
		CFG_BADGE_WIDTH,
		CFG_BADGE_HEIGHT,
		CFG_BG_COLOR,
		CFG_BORDER_COLOR,
		CFG_LINE0_COLOR,
		CFG_LINE1_COLOR
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} rgb_sum_t;

	// One entry per glyph from space to 'Z'. Column 0 is the leftmost byte;
	// bit n of a column byte is glyph row n.
	localparam logic [39:0] FONT_TAB [FONT_GLYPHS] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
		40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
		40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
		40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
		40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
		40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43
	};

	// Font pixel of a stored code at glyph column col and row. Lowercase folds
	// to uppercase; codes without a glyph give no pixel.
	function automatic logic glyph_bit(input logic [7:0] code, input logic [2:0] col,
			input logic [2:0] row);
		logic [7:0]  c;
		logic [39:0] ent;
		logic [7:0]  colb;
		logic        hit;
		c   = code;
		hit = 1'b0;
		ent = '0;
		colb = '0;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			c = c - CASE_FOLD;
		end
		if (c >= CHAR_FIRST && c <= CHAR_LAST && col < 3'(GLYPH_W)) begin
			ent  = FONT_TAB[6'(c - CHAR_FIRST)];
			colb = 8'(ent >> (6'd8 * (6'(GLYPH_W - 1) - 6'(col))));
			hit  = colb[row];
		end
		return hit;
	endfunction

endpackage

// File: rtl/osdtb_char_store.sv
module osdtb_char_store #(
	parameter int ADDR_BITS = osdtb_pkg::CELL_ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [ADDR_BITS-1:0]           rd_addr,
	output logic [osdtb_pkg::CODE_BITS-1:0] rd_code,
	input  logic                           wr_en,
	input  logic [ADDR_BITS-1:0]           wr_addr,
	input  logic [osdtb_pkg::CODE_BITS-1:0] wr_code
);
	import osdtb_pkg::*;

	localparam int DEPTH = 2 ** ADDR_BITS;

	logic [CODE_BITS-1:0] cell_mem [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [CODE_BITS-1:0] rdata_q;
	logic                 rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cell_mem[wr_addr] <= wr_code;
		end
		if (rd_en) begin
			rdata_q <= cell_mem[rd_addr];
		end
	end

	// A cell that was never written reads as blank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_code = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/osd_text_badge_overlay_unit.sv
// On-screen-display badge and text overlay for a BGRA pixel stream.
// Throughput: one item per clock unless out_ready holds the output; every
// stage is a single register, and the character store is read and written
// once per cycle at the same stage.
// Reset clears the pipeline, loads the register defaults and blanks all text cells.
module osd_text_badge_overlay_unit #(
	parameter int LINE_CHARS = osdtb_pkg::LINE_CHARS_DEF,
	parameter int COORD_BITS = osdtb_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [osdtb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [osdtb_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// Input items: pixels and character cell writes
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [COORD_BITS-1:0]              pos_x,
	input  logic [COORD_BITS-1:0]              pos_y,
	input  logic [7:0]                         blue,
	input  logic [7:0]                         green,
	input  logic [7:0]                         red,
	input  logic [7:0]                         alpha_in,
	input  logic                               text_line,
	input  logic [osdtb_pkg::COL_BITS-1:0]      text_column,
	input  logic [osdtb_pkg::CODE_BITS-1:0]     char_code,
	// Result items: one per pixel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         out_blue,
	output logic [7:0]                         out_green,
	output logic [7:0]                         out_red,
	output logic [7:0]                         out_alpha
);
	import osdtb_pkg::*;

	// Signed width that holds any coordinate minus any origin and offset.
	localparam int XW = (COORD_BITS > GEOM_BITS) ? COORD_BITS : GEOM_BITS;
	localparam int DW = XW + 2;

	// Only the first MAX_COLS cells of a line can ever be written; cells past
	// that stay blank, so they need no storage.
	localparam int STORE_CHARS = (LINE_CHARS < MAX_COLS) ? LINE_CHARS : MAX_COLS;
	localparam int SW = (STORE_CHARS > 1) ? $clog2(STORE_CHARS) : 1;
	localparam int AW = SW + 1;

	// Cell index by reciprocal multiply: dxt / PITCH = (dxt * RECIP) >> K,
	// exact for every dxt below 2**COORD_BITS since 2**(K - COORD_BITS) >= PITCH.
	localparam int K  = COORD_BITS + 4;
	localparam int RW = COORD_BITS + 1;
	localparam int PW = COORD_BITS + RW;
	localparam int CW = COORD_BITS - 3;
	localparam logic [RW-1:0] RECIP = RW'(((2 ** K) + PITCH - 1) / PITCH);

	localparam logic signed [DW-1:0] TEXT_X_E   = DW'(TEXT_X_OFF);
	localparam logic signed [DW-1:0] TEXT_Y_E   = DW'(TEXT_Y_OFF);
	localparam logic signed [DW-1:0] BORDER_E   = DW'(BORDER_ROWS);
	localparam logic signed [DW-1:0] TXT_SPAN_E = DW'(2 * LINE_PITCH_Y);

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls.
	// ------------------------------------------------------------------
	logic [GEOM_BITS-1:0] origin_x_q, origin_y_q, badge_width_q, badge_height_q;
	logic [31:0]          bg_color_q;
	logic [23:0]          border_color_q, line0_color_q, line1_color_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= ORIGIN_X_RST;
			origin_y_q     <= ORIGIN_Y_RST;
			badge_width_q  <= BADGE_WIDTH_RST;
			badge_height_q <= BADGE_HEIGHT_RST;
			bg_color_q     <= BG_COLOR_RST;
			border_color_q <= BORDER_COLOR_RST;
			line0_color_q  <= LINE0_COLOR_RST;
			line1_color_q  <= LINE1_COLOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ORIGIN_X:     origin_x_q     <= cfg_data[GEOM_BITS-1:0];
				CFG_ORIGIN_Y:     origin_y_q     <= cfg_data[GEOM_BITS-1:0];
				CFG_BADGE_WIDTH:  badge_width_q  <= cfg_data[GEOM_BITS-1:0];
				CFG_BADGE_HEIGHT: badge_height_q <= cfg_data[GEOM_BITS-1:0];
				CFG_BG_COLOR:     bg_color_q     <= cfg_data;
				CFG_BORDER_COLOR: border_color_q <= cfg_data[23:0];
				CFG_LINE0_COLOR:  line0_color_q  <= cfg_data[23:0];
				CFG_LINE1_COLOR:  line1_color_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage loads when it is empty or its
	// contents move on, so bubbles are squeezed out while the output waits.
	// Cell writes travel down to stage 3 and are dropped there, after
	// updating the store, so they never produce a result.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic en1, en2, en3, en4, en_o;

	assign en_o     = !out_valid_q || out_ready;
	assign en4      = !v_s4 || en_o;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// Stage 1: input register
	logic                  act_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	rgb_t                  pix_s1;
	logic [7:0]            a_s1;
	logic                  wline_s1;
	logic [COL_BITS-1:0]   wcol_s1;
	logic [CODE_BITS-1:0]  wcode_s1;

	// Stage 2: geometry flags and blend products
	logic                  act_s2, wok_s2, wline_s2;
	logic [COL_BITS-1:0]   wcol_s2;
	logic [CODE_BITS-1:0]  wcode_s2;
	logic                  badge_s2, border_s2;
	rgb_sum_t              sum_s2;
	rgb_t                  pix_s2;
	logic [7:0]            a_s2;
	logic                  txt_ok_s2, tline_s2;
	logic [2:0]            row_s2;
	logic [COORD_BITS-1:0] dxt_s2;

	// Stage 3: layered background color, character cell index
	logic                  act_s3, wok_s3, wline_s3;
	logic [COL_BITS-1:0]   wcol_s3;
	logic [CODE_BITS-1:0]  wcode_s3;
	rgb_t                  pre_s3;
	logic [7:0]            a_s3;
	logic                  txt_ok_s3, tline_s3;
	logic [2:0]            row_s3;
	logic [COORD_BITS-1:0] dxt_s3;
	logic [CW-1:0]         cell_s3;

	// Stage 4: glyph position, stored code comes out of the store
	rgb_t                  pre_s4;
	logic [7:0]            a_s4;
	logic                  txt_ok_s4, tline_s4;
	logic [2:0]            row_s4, col_s4;
	logic [CODE_BITS-1:0]  code_s4;

	// Output register
	rgb_t                  out_pix_q;
	logic [7:0]            out_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3 && !act_s3;
			end
			if (en_o) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 to 2: position against the badge and the text lines, and the
	// two products of the alpha blend.
	// ------------------------------------------------------------------
	logic signed [DW-1:0] x_e, y_e, ox_e, oy_e, bw_e, bh_e;
	logic signed [DW-1:0] dx, dy, dxt, dyt;
	logic                 in_x, in_badge, in_border, txt_ok, wok;
	logic [7:0]           bg_a, inv_a;
	rgb_t                 bg_rgb;
	rgb_sum_t             sum;

	assign x_e  = signed'(DW'(x_s1));
	assign y_e  = signed'(DW'(y_s1));
	assign ox_e = signed'(DW'(origin_x_q));
	assign oy_e = signed'(DW'(origin_y_q));
	assign bw_e = signed'(DW'(badge_width_q));
	assign bh_e = signed'(DW'(badge_height_q));

	assign dx  = x_e - ox_e;
	assign dy  = y_e - oy_e;
	assign dxt = dx - TEXT_X_E;
	assign dyt = dy - TEXT_Y_E;

	// The border covers the two top badge rows even when the badge is shorter.
	assign in_x      = !dx[DW-1] && (dx < bw_e);
	assign in_badge  = in_x && !dy[DW-1] && (dy < bh_e);
	assign in_border = in_x && !dy[DW-1] && (dy < BORDER_E);

	// Both lines sit in a 32-row band starting at the text offset: bit 4 of
	// dyt picks the line, the low four bits give the scaled glyph row.
	assign txt_ok = !dxt[DW-1] && !dyt[DW-1] && (dyt < TXT_SPAN_E)
		&& (dyt[3:0] < 4'(GLYPH_PX_H));

	// A cell write with a column past the line length is dropped.
	assign wok = ({1'b0, wcol_s1} < (COL_BITS + 1)'(STORE_CHARS));

	assign bg_a   = bg_color_q[31:24];
	assign bg_rgb = rgb_t'(bg_color_q[23:0]);
	assign inv_a  = ALPHA_OPAQUE - bg_a;

	assign sum.red   = 16'({8'd0, pix_s1.red}   * {8'd0, inv_a})
		+ 16'({8'd0, bg_rgb.red}   * {8'd0, bg_a});
	assign sum.green = 16'({8'd0, pix_s1.green} * {8'd0, inv_a})
		+ 16'({8'd0, bg_rgb.green} * {8'd0, bg_a});
	assign sum.blue  = 16'({8'd0, pix_s1.blue}  * {8'd0, inv_a})
		+ 16'({8'd0, bg_rgb.blue}  * {8'd0, bg_a});

	// ------------------------------------------------------------------
	// Stage 2 to 3: divide the blend sums by 255, layer badge and border,
	// and form the character cell index.
	// ------------------------------------------------------------------
	rgb_t            blend, layered;
	logic            touched;
	logic [PW-1:0]   cell_prod;

	// n / 255 == (n + 1 + (n >> 8)) >> 8 for every n up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] n);
		logic [16:0] t;
		t = 17'(n) + 17'd1 + 17'(n[15:8]);
		return t[15:8];
	endfunction

	assign blend.red   = div255(sum_s2.red);
	assign blend.green = div255(sum_s2.green);
	assign blend.blue  = div255(sum_s2.blue);

	assign touched = badge_s2 || border_s2;

	always_comb begin
		priority if (border_s2) begin
			layered = rgb_t'(border_color_q);
		end else if (badge_s2) begin
			layered = blend;
		end else begin
			layered = pix_s2;
		end
	end

	assign cell_prod = PW'(dxt_s2) * PW'(RECIP);

	// ------------------------------------------------------------------
	// Stage 3 to 4: position inside the cell and the store access. Writes
	// and reads happen at the same step, so they keep stream order.
	// ------------------------------------------------------------------
	logic [COORD_BITS-1:0] ofs_in_cell;
	logic                  cell_in, glyph_in;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic                  wr_en;

	assign ofs_in_cell = dxt_s3 - COORD_BITS'(cell_s3 * PITCH);
	assign cell_in     = ({1'b0, cell_s3} < (CW + 1)'(STORE_CHARS));
	assign glyph_in    = (ofs_in_cell[3:0] < 4'(GLYPH_PX_W));

	assign rd_addr = {tline_s3, cell_s3[SW-1:0]};
	assign wr_addr = {wline_s3, wcol_s3[SW-1:0]};
	assign wr_en   = en4 && v_s3 && act_s3 && wok_s3;

	osdtb_char_store #(
		.ADDR_BITS(AW)
	) u_char_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en4),
		.rd_addr (rd_addr),
		.rd_code (code_s4),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_code (wcode_s3)
	);

	// ------------------------------------------------------------------
	// Stage 4 to output: font lookup and the text layer on top.
	// ------------------------------------------------------------------
	logic hit;
	rgb_t final_pix;

	assign hit = txt_ok_s4 && glyph_bit(code_s4, col_s4, row_s4);

	always_comb begin
		if (hit) begin
			final_pix = tline_s4 ? rgb_t'(line1_color_q) : rgb_t'(line0_color_q);
		end else begin
			final_pix = pre_s4;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en1) begin
			act_s1       <= action;
			x_s1         <= pos_x;
			y_s1         <= pos_y;
			pix_s1.red   <= red;
			pix_s1.green <= green;
			pix_s1.blue  <= blue;
			a_s1         <= alpha_in;
			wline_s1     <= text_line;
			wcol_s1      <= text_column;
			wcode_s1     <= char_code;
		end
		if (en2) begin
			act_s2    <= act_s1;
			wok_s2    <= wok;
			wline_s2  <= wline_s1;
			wcol_s2   <= wcol_s1;
			wcode_s2  <= wcode_s1;
			badge_s2  <= in_badge;
			border_s2 <= in_border;
			sum_s2    <= sum;
			pix_s2    <= pix_s1;
			a_s2      <= a_s1;
			txt_ok_s2 <= txt_ok;
			tline_s2  <= dyt[4];
			row_s2    <= dyt[3:1];
			dxt_s2    <= dxt[COORD_BITS-1:0];
		end
		if (en3) begin
			act_s3    <= act_s2;
			wok_s3    <= wok_s2;
			wline_s3  <= wline_s2;
			wcol_s3   <= wcol_s2;
			wcode_s3  <= wcode_s2;
			pre_s3    <= layered;
			a_s3      <= touched ? ALPHA_OPAQUE : a_s2;
			txt_ok_s3 <= txt_ok_s2;
			tline_s3  <= tline_s2;
			row_s3    <= row_s2;
			dxt_s3    <= dxt_s2;
			cell_s3   <= cell_prod[K +: CW];
		end
		if (en4) begin
			pre_s4    <= pre_s3;
			a_s4      <= a_s3;
			txt_ok_s4 <= txt_ok_s3 && cell_in && glyph_in;
			tline_s4  <= tline_s3;
			row_s4    <= row_s3;
			col_s4    <= ofs_in_cell[3:1];
		end
		if (en_o) begin
			out_pix_q   <= final_pix;
			out_alpha_q <= hit ? ALPHA_OPAQUE : a_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_blue  = out_pix_q.blue;
	assign out_green = out_pix_q.green;
	assign out_red   = out_pix_q.red;
	assign out_alpha = out_alpha_q;

endmodule
